// ===== hw/rtl/ddoi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ddoi_pkg;

    // rotation count of the cordic, 8 to 32
    localparam int CORDIC_STEPS = 16;

    // table depth and index width of the arctangent table
    localparam int ATAN_DEPTH = 32;
    localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

    // cordic start value, pre-scaled by the inverse gain, q2.30
    localparam logic [31:0] CORDIC_GAIN_INIT = 32'd652032874;

    // radians to binary angle, about 2^32 / (2*pi)
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;

    // unit in q2.30
    localparam int ONE_Q30 = 1073741824;

    // largest position step, 2^33 in q16.16
    localparam logic [63:0] STEP_LIMIT = 64'd8589934592;

    // configuration register index
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X       = 2'd0,
        REG_START_Y       = 2'd1,
        REG_START_HEADING = 2'd2
    } t_reg_idx;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CORD1 = 5'b00010,
        S_MUL   = 5'b00100,
        S_CORD2 = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // multiply sequence steps
    typedef enum logic [3:0] {
        MS_MUL_VX  = 4'd0,
        MS_MUL_VY  = 4'd1,
        MS_MUL_XHI = 4'd2,
        MS_MUL_XLO = 4'd3,
        MS_MUL_YHI = 4'd4,
        MS_MUL_YLO = 4'd5,
        MS_MUL_WLO = 4'd6,
        MS_MUL_WHI = 4'd7,
        MS_SUM_W   = 4'd8,
        MS_MUL_KLO = 4'd9,
        MS_MUL_KHI = 4'd10,
        MS_HEAD    = 4'd11
    } t_mstep;

    // cordic result towards the sequencer
    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } t_trig;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051D;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2F9;
            5'd15: v = 32'h0000_517C;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A2F;
            5'd19: v = 32'h0000_0517;
            5'd20: v = 32'h0000_028B;
            5'd21: v = 32'h0000_0145;
            5'd22: v = 32'h0000_00A2;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0028;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0002;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0000;
            5'd31: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ddoi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// odometry sample channel
interface ddoi_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] stamp;
    logic [31:0] lin_speed;
    logic [31:0] ang_speed;

    modport source (output valid, output stamp, output lin_speed, output ang_speed,
                    input ready);
    modport sink   (input valid, input stamp, input lin_speed, input ang_speed,
                    output ready);
endinterface

// pose result channel
interface ddoi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading_out;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic [47:0] out_stamp;

    modport source (output valid, output pos_x, output pos_y, output heading_out,
                    output quat_z, output quat_w, output out_stamp, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading_out,
                    input quat_z, input quat_w, input out_stamp, output ready);
endinterface

// register write channel
interface ddoi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  wr_index;
    logic [31:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ddoi_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddoi_cordic
    import ddoi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output t_trig       o_res
);

    logic signed [33:0]    r_x, r_y, r_z;
    logic                  r_flip;
    logic                  r_busy;
    logic                  r_done;
    logic [ATAN_IDX_W-1:0] r_cnt;

    logic [31:0]        w_rot;
    logic               w_flip;
    logic [31:0]        w_a;
    logic signed [33:0] w_dx, w_dy, w_atan;
    logic signed [33:0] w_xf, w_yf;

    // fold the angle into the right half plane
    assign w_rot  = i_angle + 32'h4000_0000;
    assign w_flip = w_rot[31];
    assign w_a    = w_flip ? (i_angle ^ 32'h8000_0000) : i_angle;

    // shifted terms of the current rotation
    assign w_dx   = r_y >>> r_cnt;
    assign w_dy   = r_x >>> r_cnt;
    assign w_atan = $signed({2'b00, atan_bam(r_cnt)});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // one rotation a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed({2'b00, CORDIC_GAIN_INIT});
            r_y    <= '0;
            r_z    <= $signed({{2{w_a[31]}}, w_a});
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    // undo the fold and clamp to plus or minus one
    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824) begin
            r = 32'(ONE_Q30);
        end else if (v < -34'sd1073741824) begin
            r = -32'(ONE_Q30);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign w_xf = r_flip ? -r_x : r_x;
    assign w_yf = r_flip ? -r_y : r_y;

    assign o_res.done  = r_done;
    assign o_res.cos_v = clamp_one(w_xf);
    assign o_res.sin_v = clamp_one(w_yf);

endmodule

`default_nettype wire

// ===== hw/rtl/diff_drive_odometry_integrator.sv =====
// Planar dead-reckoning pose integrator, fixed point.
// i_in carries timestamped samples (stamp Q32.16 s, forward and turn speed
// Q16.16); a request is taken when valid and ready are both high.
// o_out carries the pose: x and y Q16.16 saturating, heading as a 32-bit
// binary angle, the half-heading quaternion z and w in Q1.15 and the stamp.
// i_cfg writes the start pose registers; it is always ready. Before the
// first sample a write also loads the live pose component.
// The first sample after reset only records its stamp and gives no result.
// Every later sample gives one result; no new request is taken until that
// result has gone into the output register. The work goes into two passes
// of the iterative cordic, one rotation a cycle, and twelve steps of one
// shared 33x33 multiplier that builds both position steps and the
// heading step.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already taken, and only the load of that
// next result into the output register waits for the register to drain.
// Reset (synchronous, active low) clears the pose, the start registers, the
// stamp history and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry_integrator
    import ddoi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddoi_in_if.sink     i_in,
    ddoi_out_if.source  o_out,
    ddoi_cfg_if.sink    i_cfg
);

    t_state r_state, n_state;
    t_mstep r_step;

    // state and configuration
    logic               r_seen;
    logic [47:0]        r_prev_stamp;
    logic [31:0]        r_start_x, r_start_y, r_start_h;
    logic signed [31:0] r_cur_x, r_cur_y;
    logic [31:0]        r_cur_h;

    // working registers of one request
    logic signed [48:0] r_dt;
    logic signed [31:0] r_v, r_w;
    logic [47:0]        r_stamp;
    logic signed [31:0] r_cos, r_sin;
    logic signed [65:0] r_mul;
    logic [31:0]        r_max, r_may;
    logic               r_negx, r_negy;
    logic [63:0]        r_accx, r_accy;
    logic signed [34:0] r_stp;
    logic [63:0]        r_ph;
    logic [31:0]        r_hd;
    logic [15:0]        r_qz, r_qw;
    logic               r_cstart;

    // output register
    logic               r_ovalid;
    logic [31:0]        r_o_x, r_o_y, r_o_h;
    logic [15:0]        r_o_qz, r_o_qw;
    logic [47:0]        r_o_stamp;

    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_load;
    logic [31:0]        w_angle;
    t_trig              w_trig;
    logic signed [32:0] w_ma, w_mb;
    logic signed [48:0] w_dt_neg;
    logic [47:0]        w_mag_dt;
    logic signed [33:0] w_vc, w_vc_abs;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_load      = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);

    // shared cordic, second pass works on the half heading
    assign w_angle = (r_state == S_CORD2) ? {1'b0, r_cur_h[31:1]} : r_cur_h;

    ddoi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_angle (w_angle),
        .o_res   (w_trig)
    );

    // magnitude of dt and of the projected speed
    assign w_dt_neg = -r_dt;
    assign w_mag_dt = r_dt[48] ? w_dt_neg[47:0] : r_dt[47:0];
    assign w_vc     = r_mul[63:30];
    assign w_vc_abs = w_vc[33] ? -w_vc : w_vc;

    // step clamp to plus or minus 2^33 with the sign applied
    function automatic logic signed [34:0] signed_step(input logic [63:0] acc,
                                                       input logic neg);
        logic [33:0]        mag;
        logic signed [34:0] s;
        mag = (acc > STEP_LIMIT) ? STEP_LIMIT[33:0] : acc[33:0];
        s   = $signed({1'b0, mag});
        return neg ? -s : s;
    endfunction

    // saturating position update
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] cur,
                                                   input logic signed [34:0] stp);
        logic signed [35:0] sum;
        logic signed [31:0] r;
        sum = $signed({{4{cur[31]}}, cur}) + $signed({stp[34], stp});
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
            r = sum[31:0];
        end else if (sum[35]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // q2.30 to q1.15, floor then clamp
    function automatic logic [15:0] to_q15(input logic signed [31:0] v);
        logic [16:0] t;
        logic [15:0] r;
        t = v[31:15];
        if (!t[16] && t[15]) begin
            r = 16'h7FFF;
        end else if (t[16] && !t[15]) begin
            r = 16'h8000;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_step)
            MS_MUL_VX: begin
                w_ma = {r_v[31], r_v};
                w_mb = {r_cos[31], r_cos};
            end
            MS_MUL_VY: begin
                w_ma = {r_v[31], r_v};
                w_mb = {r_sin[31], r_sin};
            end
            MS_MUL_XHI: begin
                w_ma = {1'b0, r_max};
                w_mb = {9'b0, w_mag_dt[47:24]};
            end
            MS_MUL_XLO: begin
                w_ma = {1'b0, r_max};
                w_mb = {9'b0, w_mag_dt[23:0]};
            end
            MS_MUL_YHI: begin
                w_ma = {1'b0, r_may};
                w_mb = {9'b0, w_mag_dt[47:24]};
            end
            MS_MUL_YLO: begin
                w_ma = {1'b0, r_may};
                w_mb = {9'b0, w_mag_dt[23:0]};
            end
            MS_MUL_WLO: begin
                w_ma = {r_w[31], r_w};
                w_mb = {9'b0, r_dt[23:0]};
            end
            MS_MUL_WHI: begin
                w_ma = {r_w[31], r_w};
                w_mb = {{8{r_dt[48]}}, r_dt[48:24]};
            end
            MS_MUL_KLO: begin
                w_ma = {1'b0, r_ph[31:0]};
                w_mb = {3'b0, RAD_TO_BAM};
            end
            MS_MUL_KHI: begin
                w_ma = {1'b0, r_ph[63:32]};
                w_mb = {3'b0, RAD_TO_BAM};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && r_seen) n_state = S_CORD1;
            S_CORD1: if (w_trig.done) n_state = S_MUL;
            S_MUL:   if (r_step == MS_HEAD) n_state = S_CORD2;
            S_CORD2: if (w_trig.done) n_state = S_EMIT;
            S_EMIT:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= MS_MUL_VX;
            r_cstart <= 1'b0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cstart <= (r_state == S_IDLE && w_in_acc && r_seen) ||
                        (r_state == S_MUL && r_step == MS_HEAD);
            if (w_in_acc) begin
                r_seen <= 1'b1;
            end
            if (r_state == S_CORD1) begin
                r_step <= MS_MUL_VX;
            end else if (r_state == S_MUL) begin
                r_step <= t_mstep'(r_step + 4'd1);
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // pose, start registers and stamp history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_start_h    <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_h      <= '0;
            r_prev_stamp <= '0;
        end else begin
            // register write, also seeds the pose before the first sample
            if (w_cfg_acc) begin
                unique case (i_cfg.wr_index)
                    REG_START_X: begin
                        r_start_x <= i_cfg.wr_data;
                        if (!r_seen) r_cur_x <= i_cfg.wr_data;
                    end
                    REG_START_Y: begin
                        r_start_y <= i_cfg.wr_data;
                        if (!r_seen) r_cur_y <= i_cfg.wr_data;
                    end
                    REG_START_HEADING: begin
                        r_start_h <= i_cfg.wr_data;
                        if (!r_seen) r_cur_h <= i_cfg.wr_data;
                    end
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_prev_stamp <= i_in.stamp;
            end
            // pose write-back from the multiply sequence
            if (r_state == S_MUL) begin
                unique case (r_step)
                    MS_MUL_WLO: r_cur_x <= sat_add(r_cur_x, r_stp);
                    MS_SUM_W:   r_cur_y <= sat_add(r_cur_y, r_stp);
                    MS_HEAD:    r_cur_h <= r_cur_h + r_hd + r_mul[31:0];
                    default: ;
                endcase
            end
        end
    end

    // request capture, multiplier and partial sums
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_dt    <= $signed({1'b0, i_in.stamp}) - $signed({1'b0, r_prev_stamp});
            r_v     <= i_in.lin_speed;
            r_w     <= i_in.ang_speed;
            r_stamp <= i_in.stamp;
        end
        if (r_state == S_CORD1 && w_trig.done) begin
            r_cos <= w_trig.cos_v;
            r_sin <= w_trig.sin_v;
        end
        if (r_state == S_CORD2 && w_trig.done) begin
            r_qz <= to_q15(w_trig.sin_v);
            r_qw <= to_q15(w_trig.cos_v);
        end
        if (r_state == S_MUL) begin
            r_mul <= w_ma * w_mb;
            // each step takes the product issued one step earlier
            unique case (r_step)
                MS_MUL_VY: begin
                    r_max  <= w_vc_abs[31:0];
                    r_negx <= w_vc[33] ^ r_dt[48];
                end
                MS_MUL_XHI: begin
                    r_may  <= w_vc_abs[31:0];
                    r_negy <= w_vc[33] ^ r_dt[48];
                end
                MS_MUL_XLO: r_accx <= {r_mul[55:0], 8'b0};
                MS_MUL_YHI: r_accx <= r_accx + {24'b0, r_mul[55:16]};
                MS_MUL_YLO: begin
                    r_accy <= {r_mul[55:0], 8'b0};
                    r_stp  <= signed_step(r_accx, r_negx);
                end
                MS_MUL_WLO: r_accy <= r_accy + {24'b0, r_mul[55:16]};
                MS_MUL_WHI: begin
                    r_ph  <= r_mul[63:0];
                    r_stp <= signed_step(r_accy, r_negy);
                end
                MS_SUM_W:   r_ph <= r_ph + {r_mul[39:0], 24'b0};
                MS_MUL_KHI: r_hd <= r_mul[63:32];
                default: ;
            endcase
        end
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_x     <= r_cur_x;
            r_o_y     <= r_cur_y;
            r_o_h     <= r_cur_h;
            r_o_qz    <= r_qz;
            r_o_qw    <= r_qw;
            r_o_stamp <= r_stamp;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.pos_x       = r_o_x;
    assign o_out.pos_y       = r_o_y;
    assign o_out.heading_out = r_o_h;
    assign o_out.quat_z      = r_o_qz;
    assign o_out.quat_w      = r_o_qw;
    assign o_out.out_stamp   = r_o_stamp;

endmodule

`default_nettype wire

// ===== hw/rtl/ddoi_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddoi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_pos_x,
    input logic [31:0] i_pos_y,
    input logic [31:0] i_heading,
    input logic [15:0] i_quat_z,
    input logic [15:0] i_quat_w,
    input logic [47:0] i_stamp
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos_x) &&
        $stable(i_pos_y) && $stable(i_heading) && $stable(i_quat_z) &&
        $stable(i_quat_w) && $stable(i_stamp))
        else $error("result changed while stalled");

    // a new result is only written while the input side is busy
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a request in work");

    // input side only goes busy after a request
    a_busy_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid))
        else $error("ready dropped without a request");

    // reset empties the output and frees the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("reset did not clear the block");

endmodule

bind diff_drive_odometry_integrator ddoi_chk u_ddoi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pos_x     (o_out.pos_x),
    .i_pos_y     (o_out.pos_y),
    .i_heading   (o_out.heading_out),
    .i_quat_z    (o_out.quat_z),
    .i_quat_w    (o_out.quat_w),
    .i_stamp     (o_out.out_stamp)
);

`default_nettype wire
